>>> design/asm_pkg.sv
// Shared types and constants of the approximate substring match unit.
// No dependencies; compile first.
`timescale 1ns / 1ps

package asm_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int DIST_BITS       = 6;
    localparam int LEN_BITS        = 6;
    localparam int PAT_WORDS       = 4;
    localparam int PAT_CHARS       = PAT_WORDS * 8;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 64;
    localparam int DIST_MAX        = 63;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int CHAR_BITS_DEF   = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD0  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD1  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD2  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD3  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ERRORS     = 3'd5;

    typedef logic [DIST_BITS-1:0] dist_t;

    // Data handed from one cell to the next
    typedef struct packed {
        logic                 fire;
        logic                 last;
        logic [BYTE_BITS-1:0] ch;
        dist_t                left;
        dist_t                diag;
    } asm_link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } asm_state_t;

endpackage

>>> design/asm_in_if.sv
// Text item channel: valid/ready plus one text byte and its end mark.
// Depends on asm_pkg.
`timescale 1ns / 1ps

interface asm_in_if;
    import asm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] text_char;
    logic                 end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

>>> design/asm_out_if.sv
// Result channel: valid/ready plus distance, found flag and end mark.
// Depends on asm_pkg.
`timescale 1ns / 1ps

interface asm_out_if;
    import asm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DIST_BITS-1:0] end_distance;
    logic                 found_so_far;
    logic                 text_done;

    modport source (output valid, output end_distance, output found_so_far,
                    output text_done, input ready);
    modport sink   (input valid, input end_distance, input found_so_far,
                    input text_done, output ready);
endinterface

>>> design/asm_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on asm_pkg.
`timescale 1ns / 1ps

interface asm_cfg_if;
    import asm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/approximate_substring_match_unit.sv
// Top level of the approximate substring match unit: configuration
// registers, item control and the cell chain. Depends on asm_pkg, the
// asm_*_if interfaces and asm_cell.
`timescale 1ns / 1ps

// Usage
//   text_in    : one text byte per transfer, end_of_text marks the last one.
//   result_out : one result per text byte: distance of the whole pattern
//                ending there, sticky found flag, and the end mark echoed.
//   cfg        : register writes (pattern words 0..3, pattern_length,
//                max_errors); ready is always high, write only while idle.
// Item flow
//   One item is in the chain at a time. After a text transfer the
//   wavefront walks the MAX_PATTERN cells at one cell per cycle. The
//   result is registered once the wavefront leaves the last cell and the
//   output register is free, and text_in.ready returns at the same time:
//   no new text byte is taken before the last one is through the chain.
// Reset and stalls
//   Reset clears the configuration and control registers; reset and every
//   end_of_text item load column entry j with j+1 and clear the found flag.
//   A finished result waits in the output register while the receiver
//   stalls; the next text byte is still taken and runs through the chain,
//   and its result holds until the output register frees up.

module approximate_substring_match_unit #(
    parameter int MAX_PATTERN = asm_pkg::MAX_PATTERN_DEF,
    parameter int CHAR_BITS   = asm_pkg::CHAR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    asm_in_if.sink     text_in,
    asm_out_if.source  result_out,
    asm_cfg_if.sink    cfg
);
    import asm_pkg::*;

    // active length never exceeds the chain or the pattern registers
    localparam int LEN_CAP = (MAX_PATTERN < PAT_CHARS) ? MAX_PATTERN : PAT_CHARS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_DATA_BITS-1:0] pattern_word_reg [PAT_WORDS];
    logic [LEN_BITS-1:0]      pattern_length_reg;
    logic [LEN_BITS-1:0]      max_errors_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < PAT_WORDS; w++)
                pattern_word_reg[w] <= '0;
            pattern_length_reg <= '0;
            max_errors_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PATTERN_WORD0:  pattern_word_reg[0] <= cfg.data;
                REG_PATTERN_WORD1:  pattern_word_reg[1] <= cfg.data;
                REG_PATTERN_WORD2:  pattern_word_reg[2] <= cfg.data;
                REG_PATTERN_WORD3:  pattern_word_reg[3] <= cfg.data;
                REG_PATTERN_LENGTH: pattern_length_reg  <= cfg.data[LEN_BITS-1:0];
                REG_MAX_ERRORS:     max_errors_reg      <= cfg.data[LEN_BITS-1:0];
                default:            ; // drop writes to unused indexes
            endcase
        end
    end

    logic [PAT_WORDS*CFG_DATA_BITS-1:0] pattern_flat;
    logic [LEN_BITS-1:0]                act_len;

    always_comb
    begin
        for (int w = 0; w < PAT_WORDS; w++)
            pattern_flat[w*CFG_DATA_BITS +: CFG_DATA_BITS] = pattern_word_reg[w];
        act_len = (pattern_length_reg > LEN_BITS'(LEN_CAP)) ? LEN_BITS'(LEN_CAP)
                                                            : pattern_length_reg;
    end

    // ---------------------------------------------------------------
    // Item control
    // ---------------------------------------------------------------
    asm_state_t           state_reg, state_next;
    logic                 start_reg;
    logic [BYTE_BITS-1:0] item_ch_reg;
    logic                 item_last_reg;
    dist_t                dist_hold_reg, dist_hold_next;
    logic                 found_reg, found_next;
    logic                 out_valid_reg, out_valid_next;
    dist_t                out_dist_reg;
    logic                 out_found_reg;
    logic                 out_done_reg;

    logic       in_xfer;
    logic       load_out;
    logic       chain_done;
    asm_link_t  links [MAX_PATTERN+1];

    assign in_xfer    = text_in.valid && text_in.ready;
    assign chain_done = links[MAX_PATTERN].fire;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer)    state_next = ST_RUN;
            ST_RUN:  if (chain_done) state_next = ST_HOLD;
            ST_HOLD: if (load_out)   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        text_in.ready = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: text_in.ready = 1'b1;
            ST_RUN:  ;
            ST_HOLD: load_out = !out_valid_reg || result_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_xfer;
        end
    end

    // hold the item for the chain entry and for the result's end mark
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_ch_reg   <= text_in.text_char;
            item_last_reg <= text_in.end_of_text;
        end
    end

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    assign links[0] = '{fire: start_reg, last: item_last_reg, ch: item_ch_reg,
                        left: '0, diag: '0};

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_chain
        logic [BYTE_BITS-1:0] pat_char;

        if (k < PAT_CHARS)
        begin : g_pat
            assign pat_char = pattern_flat[k*BYTE_BITS +: BYTE_BITS];
        end
        else
        begin : g_zero
            // characters beyond the pattern registers read as zero
            assign pat_char = '0;
        end

        asm_cell #(
            .CELL_INDEX (k),
            .CHAR_BITS  (CHAR_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .pat_char (pat_char),
            .link_in  (links[k]),
            .link_out (links[k+1])
        );
    end

    // tap the new value of the cell at the pattern end as the wavefront leaves it
    always_comb
    begin
        dist_hold_next = dist_hold_reg;
        for (int k = 0; k < LEN_CAP; k++)
        begin
            if (links[k+1].fire && act_len == LEN_BITS'(k + 1))
                dist_hold_next = links[k+1].left;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_hold_reg <= dist_hold_next;
    end

    // ---------------------------------------------------------------
    // Result register and found flag
    // ---------------------------------------------------------------
    dist_t result_dist;

    always_comb
    begin
        result_dist = (act_len == '0) ? '0 : dist_hold_reg;
        found_next  = found_reg || (result_dist <= max_errors_reg)
                                || (act_len <= max_errors_reg);
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load_out)
                found_reg <= item_last_reg ? 1'b0 : found_next; // restart after end of text
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_dist_reg  <= result_dist;
            out_found_reg <= found_next;
            out_done_reg  <= item_last_reg;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.end_distance = out_dist_reg;
    assign result_out.found_so_far = out_found_reg;
    assign result_out.text_done    = out_done_reg;

endmodule

>>> design/asm_cell.sv
// One cell of the distance chain: holds one column entry and updates it
// when the wavefront passes. Depends on asm_pkg.
`timescale 1ns / 1ps

module asm_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CHAR_BITS  = asm_pkg::CHAR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [asm_pkg::BYTE_BITS-1:0] pat_char,
    input  asm_pkg::asm_link_t            link_in,
    output asm_pkg::asm_link_t            link_out
);
    import asm_pkg::*;

    localparam int CMP_BITS = (CHAR_BITS < BYTE_BITS) ? CHAR_BITS : BYTE_BITS;
    localparam int INIT_VAL = (CELL_INDEX + 1 > DIST_MAX) ? DIST_MAX : CELL_INDEX + 1;

    dist_t                dist_reg, dist_next;
    logic                 fire_reg;
    logic                 last_reg;
    logic [BYTE_BITS-1:0] ch_reg;
    dist_t                left_reg, left_next;
    dist_t                diag_reg;

    logic  match;
    dist_t min_val;
    dist_t step_val;

    always_comb
    begin
        match   = (pat_char[CMP_BITS-1:0] == link_in.ch[CMP_BITS-1:0]);
        min_val = dist_reg;
        if (link_in.left < min_val)
            min_val = link_in.left;
        if (link_in.diag < min_val)
            min_val = link_in.diag;
        // saturate at the top of the distance range
        step_val  = (min_val == DIST_BITS'(DIST_MAX)) ? min_val : min_val + 1'b1;
        left_next = match ? link_in.diag : step_val;
        dist_next = dist_reg;
        if (link_in.fire)
            dist_next = link_in.last ? DIST_BITS'(INIT_VAL) : left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= DIST_BITS'(INIT_VAL);
            fire_reg <= 1'b0;
        end
        else
        begin
            dist_reg <= dist_next;
            fire_reg <= link_in.fire;
        end
    end

    // pass the wavefront on: new value as left, old value as diagonal
    always_ff @(posedge clk)
    begin
        if (link_in.fire)
        begin
            last_reg <= link_in.last;
            ch_reg   <= link_in.ch;
            left_reg <= left_next;
            diag_reg <= dist_reg;
        end
    end

    assign link_out = '{fire: fire_reg, last: last_reg, ch: ch_reg,
                        left: left_reg, diag: diag_reg};

endmodule

>>> design/asm_checker.sv
// Port-level assertions for the approximate substring match unit, bound
// to the top level. Depends on asm_pkg and approximate_substring_match_unit.
`timescale 1ns / 1ps

module asm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [asm_pkg::DIST_BITS-1:0] end_distance,
    input logic                          found_so_far,
    input logic                          text_done
);
    import asm_pkg::*;

    // one item at a time: the chain walk keeps the input closed for a while
    a_in_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("text input reopened right after a transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(end_distance)
            && $stable(found_so_far) && $stable(text_done))
        else $error("stalled result changed");

    // the distance never exceeds PAT_CHARS, the characters the pattern registers hold
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> end_distance <= DIST_BITS'(PAT_CHARS))
        else $error("end distance out of range");

endmodule

bind approximate_substring_match_unit asm_checker u_asm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (text_in.valid),
    .in_ready     (text_in.ready),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .end_distance (result_out.end_distance),
    .found_so_far (result_out.found_so_far),
    .text_done    (result_out.text_done)
);
